/* sv/vca_pkg.sv */
// vca_pkg: shared constants, codes and table control types for the voice channel allocator
// no dependencies; compiled first
package vca_pkg;

	// table geometry
	localparam int VOICES      = 8;
	localparam int ORIGIN_BITS = 16;
	localparam int VIDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CNT_W       = $clog2(VOICES + 1);

	// field widths of the channels
	localparam int CMD_W   = 2;
	localparam int ORG_W   = 16;
	localparam int PRI_W   = 8;
	localparam int SND_W   = 8;
	localparam int VSEL_W  = 3;
	localparam int ACT_W   = 4;
	localparam int CFG_W   = 4;
	localparam int REGI_W  = 1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_START    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STOP_ORG = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

	// configuration register indexes
	localparam logic [REGI_W-1:0] REG_SOUND_ENABLED = 1'd0;
	localparam logic [REGI_W-1:0] REG_ACTIVE_VOICES = 1'd1;

	// sequencer to voice table
	typedef struct packed {
		logic [VIDX_W-1:0]      idx;
		logic                   stop;
		logic                   take;
		logic [ORIGIN_BITS-1:0] org;
		logic [PRI_W-1:0]       pri;
		logic [SND_W-1:0]       snd;
	} tbl_ctl_t;

	// voice table to sequencer, all for the entry at ctl.idx
	typedef struct packed {
		logic             busy;
		logic             org_hit;
		logic             pri_hit;
		logic [SND_W-1:0] sound;
	} tbl_stat_t;

endpackage

/* sv/vca_cmd_if.sv */
// vca_cmd_if: request channel of the voice channel allocator
// depends on vca_pkg for field widths
interface vca_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [vca_pkg::CMD_W-1:0]   command;
	logic [vca_pkg::ORG_W-1:0]   origin_id;
	logic [vca_pkg::PRI_W-1:0]   priority_req;
	logic [vca_pkg::SND_W-1:0]   sound_id;
	logic [vca_pkg::VSEL_W-1:0]  voice_index;

	modport source (output valid, command, origin_id, priority_req, sound_id, voice_index,
		input ready);
	modport sink (input valid, command, origin_id, priority_req, sound_id, voice_index,
		output ready);
endinterface

/* sv/vca_res_if.sv */
// vca_res_if: result channel of the voice channel allocator
// depends on vca_pkg for field widths
interface vca_res_if;
	logic                        valid;
	logic                        ready;
	logic                        granted;
	logic [vca_pkg::VSEL_W-1:0]  granted_voice;
	logic                        freed_valid;
	logic [vca_pkg::VSEL_W-1:0]  freed_voice;
	logic [vca_pkg::SND_W-1:0]   freed_sound;

	modport source (output valid, granted, granted_voice, freed_valid, freed_voice, freed_sound,
		input ready);
	modport sink (input valid, granted, granted_voice, freed_valid, freed_voice, freed_sound,
		output ready);
endinterface

/* sv/vca_voice_table.sv */
// vca_voice_table: per-voice busy flags and origin/priority/sound store with the shared compare
// depends on vca_pkg for geometry and the table control structs
module vca_voice_table (
	input  logic               clk,
	input  logic               arst_n,
	input  vca_pkg::tbl_ctl_t  ctl,
	output vca_pkg::tbl_stat_t stat
);
	import vca_pkg::*;

	logic [VOICES-1:0]      busy_q;
	logic [ORIGIN_BITS-1:0] origin_q [VOICES];
	logic [PRI_W-1:0]       prio_q   [VOICES];
	logic [SND_W-1:0]       sound_q  [VOICES];

	// busy flags: take wins over stop on the same voice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (ctl.take) begin
			busy_q[ctl.idx] <= 1'b1;
		end else if (ctl.stop) begin
			busy_q[ctl.idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			origin_q[ctl.idx] <= ctl.org;
			prio_q[ctl.idx]   <= ctl.pri;
			sound_q[ctl.idx]  <= ctl.snd;
		end
	end

	// one compare unit, shared by every scan step
	always_comb begin
		stat.busy    = busy_q[ctl.idx];
		stat.org_hit = (origin_q[ctl.idx] == ctl.org);
		stat.pri_hit = (prio_q[ctl.idx] >= ctl.pri);
		stat.sound   = sound_q[ctl.idx];
	end

endmodule

/* sv/voice_channel_allocator.sv */
// voice_channel_allocator: start/stop/release/clear of sound voices with priority eviction
// requests are served by the one-voice-per-cycle scan of the shared compare unit over the
// n active voices (n = active voice count, at most 8); a start scans up to three passes
// cmd.ready is high only while the sequencer is idle, and a stalled result holds the
// sequencer until it is taken
// reset: arst_n clears all busy flags, the sequencer and the result register; sound is
// enabled and all voices are active after reset
module voice_channel_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	vca_cmd_if.sink                      cmd,
	vca_res_if.source                    res,
	input  logic                         cfg_wr_en,
	input  logic [vca_pkg::REGI_W-1:0]   cfg_index,
	input  logic [vca_pkg::CFG_W-1:0]    cfg_data
);
	import vca_pkg::*;

	// one-hot sequencer states
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ORG   = 7'b0000010,   // first busy voice with the same origin
		ST_FREE  = 7'b0000100,   // first free voice, or same nonzero origin
		ST_PRI   = 7'b0001000,   // eviction by priority
		ST_CLEAR = 7'b0010000,   // stop every active voice
		ST_REL   = 7'b0100000,   // stop one voice by index
		ST_DONE  = 7'b1000000    // hand result to the output register
	} state_t;

	state_t state_q;

	// configuration
	logic             sound_enabled_q;
	logic [ACT_W-1:0] active_voices_q;

	// latched request
	logic [CMD_W-1:0]       cmd_q;
	logic [ORIGIN_BITS-1:0] org_q;
	logic [PRI_W-1:0]       pri_q;
	logic [SND_W-1:0]       snd_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       idx_q;

	// result being built
	logic              granted_q;
	logic [VIDX_W-1:0] gvoice_q;
	logic              fr_valid_q;
	logic [VIDX_W-1:0] fr_voice_q;
	logic [SND_W-1:0]  fr_sound_q;

	// output register
	logic              res_valid_q;
	logic              res_granted_q;
	logic [VSEL_W-1:0] res_gvoice_q;
	logic              res_fvalid_q;
	logic [VSEL_W-1:0] res_fvoice_q;
	logic [SND_W-1:0]  res_fsound_q;

	tbl_ctl_t  tctl;
	tbl_stat_t tstat;

	logic             in_range;
	logic             hit_org;
	logic             org_nz;
	logic             cmd_acc;
	logic             res_free;
	logic [CNT_W-1:0] n_live;
	logic             rel_ok;

	vca_voice_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tctl),
		.stat   (tstat)
	);

	assign cmd.ready     = (state_q == ST_IDLE);
	assign cmd_acc       = cmd.valid && cmd.ready;
	assign res.valid     = res_valid_q;
	assign res.granted       = res_granted_q;
	assign res.granted_voice = res_gvoice_q;
	assign res.freed_valid   = res_fvalid_q;
	assign res.freed_voice   = res_fvoice_q;
	assign res.freed_sound   = res_fsound_q;
	assign res_free      = !res_valid_q || res.ready;

	// active count clamped to the built voice count
	always_comb begin
		if (32'(active_voices_q) > VOICES) begin
			n_live = CNT_W'(VOICES);
		end else begin
			n_live = CNT_W'(active_voices_q);
		end
		rel_ok = 32'(cmd.voice_index) < 32'(n_live);
	end

	assign in_range = idx_q < n_q;
	assign org_nz   = (org_q != '0);
	assign hit_org  = tstat.busy && tstat.org_hit;

	// drive the shared compare unit and the table write strobes
	always_comb begin
		tctl.idx  = idx_q[VIDX_W-1:0];
		tctl.org  = org_q;
		tctl.pri  = pri_q;
		tctl.snd  = snd_q;
		tctl.stop = 1'b0;
		tctl.take = 1'b0;
		case (state_q)
			ST_ORG: begin
				tctl.stop = in_range && hit_org;
			end
			ST_FREE: begin
				// a busy voice of the same nonzero origin is stopped and reused
				tctl.stop = in_range && org_nz && hit_org;
				tctl.take = in_range && (!tstat.busy || (org_nz && tstat.org_hit));
			end
			ST_PRI: begin
				// every active voice is busy here; evict the first one whose stored priority is >= the request's
				tctl.stop = in_range && tstat.busy && tstat.pri_hit;
				tctl.take = in_range && tstat.pri_hit;
			end
			ST_CLEAR: begin
				tctl.stop = in_range && tstat.busy;
			end
			ST_REL: begin
				// index was checked against the active count on accept
				tctl.stop = tstat.busy;
			end
			default: begin
				tctl.stop = 1'b0;
				tctl.take = 1'b0;
			end
		endcase
	end

	// configuration registers; the user writes them only while idle, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_enabled_q <= 1'b1;
			active_voices_q <= ACT_W'(8);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SOUND_ENABLED: sound_enabled_q <= cfg_data[0];
				REG_ACTIVE_VOICES: active_voices_q <= cfg_data[ACT_W-1:0];
				default: ;
			endcase
		end
	end

	// request payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_q <= cmd.command;
			org_q <= ORIGIN_BITS'(cmd.origin_id);
			pri_q <= cmd.priority_req;
			snd_q <= cmd.sound_id;
			n_q   <= n_live;
		end
	end

	// sequencer and result collection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			granted_q  <= 1'b0;
			gvoice_q   <= '0;
			fr_valid_q <= 1'b0;
			fr_voice_q <= '0;
			fr_sound_q <= '0;
		end else begin
			// first stop of a request is the one reported
			if (tctl.stop && !fr_valid_q) begin
				fr_valid_q <= 1'b1;
				fr_voice_q <= idx_q[VIDX_W-1:0];
				fr_sound_q <= tstat.sound;
			end
			if (tctl.take) begin
				granted_q <= 1'b1;
				gvoice_q  <= idx_q[VIDX_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						granted_q  <= 1'b0;
						gvoice_q   <= '0;
						fr_valid_q <= 1'b0;
						fr_voice_q <= '0;
						fr_sound_q <= '0;
						idx_q      <= '0;
						if (!sound_enabled_q) begin
							// no effects device: all-zero result, table untouched
							state_q <= ST_DONE;
						end else begin
							case (cmd.command)
								CMD_START, CMD_STOP_ORG: state_q <= ST_ORG;
								CMD_CLEAR:               state_q <= ST_CLEAR;
								CMD_RELEASE: begin
									if (rel_ok) begin
										idx_q   <= CNT_W'(cmd.voice_index);
										state_q <= ST_REL;
									end else begin
										state_q <= ST_DONE;
									end
								end
								default: state_q <= ST_DONE;
							endcase
						end
					end
				end
				ST_ORG: begin
					if (!in_range || hit_org) begin
						idx_q   <= '0;
						state_q <= (cmd_q == CMD_START) ? ST_FREE : ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FREE: begin
					if (!in_range) begin
						idx_q   <= '0;
						state_q <= ST_PRI;
					end else if (tctl.take) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_PRI: begin
					if (!in_range || tctl.take) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CLEAR: begin
					if (!in_range) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_REL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// wait until the output register can take the result
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: holds a result while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_granted_q <= 1'b0;
			res_gvoice_q  <= '0;
			res_fvalid_q  <= 1'b0;
			res_fvoice_q  <= '0;
			res_fsound_q  <= '0;
		end else if (state_q == ST_DONE && res_free) begin
			res_granted_q <= granted_q;
			res_gvoice_q  <= VSEL_W'(gvoice_q);
			res_fvalid_q  <= fr_valid_q;
			res_fvoice_q  <= VSEL_W'(fr_voice_q);
			res_fsound_q  <= fr_sound_q;
		end
	end

endmodule

/* sv/vca_checker.sv */
// vca_checker: port-level checks of the voice channel allocator, attached by bind
// depends on vca_pkg for field widths and on voice_channel_allocator for the bind target
module vca_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cmd_valid,
	input logic                        cmd_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic                        granted,
	input logic [vca_pkg::VSEL_W-1:0]  granted_voice,
	input logic                        freed_valid,
	input logic [vca_pkg::VSEL_W-1:0]  freed_voice,
	input logic [vca_pkg::SND_W-1:0]   freed_sound
);
	import vca_pkg::*;

	// a request keeps the sequencer busy for at least the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("request taken on back-to-back cycles");

	// a result without a grant reports voice zero
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !granted |-> granted_voice == '0)
		else $error("granted_voice nonzero without grant");

	// nothing stopped means zero voice and sound
	a_freed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !freed_valid |-> freed_voice == '0 && freed_sound == '0)
		else $error("freed fields nonzero without a stop");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(granted) && $stable(granted_voice)
			&& $stable(freed_valid) && $stable(freed_voice) && $stable(freed_sound))
		else $error("stalled result changed");

endmodule

bind voice_channel_allocator vca_checker u_vca_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.granted       (res.granted),
	.granted_voice (res.granted_voice),
	.freed_valid   (res.freed_valid),
	.freed_voice   (res.freed_voice),
	.freed_sound   (res.freed_sound)
);
